/* hdl/rpbm_pkg.sv */
package rpbm_pkg;

  localparam int PIXEL_W = 32;
  localparam int CHAN_W = 8;
  localparam int CFG_W = 3;
  localparam int CFG_INDEX_W = 1;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [CFG_W-1:0] cfg_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_BLEND_MODE = 1'b0;
  localparam cfg_index_t REG_SOURCE_COUNT = 1'b1;

  localparam cfg_t MODE_ADD_CLAMP = 3'd0;
  localparam cfg_t MODE_ADD_WRAP = 3'd1;
  localparam cfg_t MODE_SUB_CLAMP = 3'd2;
  localparam cfg_t MODE_SUB_WRAP = 3'd3;
  localparam cfg_t MODE_MULTIPLY = 3'd4;
  localparam cfg_t MODE_ALPHA = 3'd5;

  localparam cfg_t RESET_BLEND_MODE = MODE_ADD_CLAMP;
  localparam cfg_t RESET_SOURCE_COUNT = 3'd1;

  localparam chan_t OPAQUE = 8'hFF;

  // Exact floor(x / 255) for any 32-bit x, by multiplying with the reciprocal.
  function automatic logic [31:0] div255(input logic [31:0] x);
    logic [63:0] prod;
    prod = {32'd0, x} * 64'h0000_0000_8080_8081;
    return {7'd0, prod[63:39]};
  endfunction

endpackage

/* hdl/rgb_pixel_blend_merge.sv */
// Channel  | Signals                                          | Direction
// pixel    | pixel_valid, pixel_ready, base_pixel, *_source_pixel | in
// merged   | merged_valid, merged_ready, merged_pixel         | out
// config   | cfg_write, cfg_index, cfg_data                   | in
// One pixel is taken per cycle while pixel_ready is high; new pixels enter before earlier ones leave.
// The pipeline is made of the input stage, one fold stage per source and one
// divide-by-255 stage per source.
// Reset clears all stage valid bits and sets blend_mode to 0 and source_count to 1.
// A stalled output holds its pixel, and empty stages behind it still fill.
module rgb_pixel_blend_merge #(
  parameter int MAX_SOURCES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_ready,
  input  rpbm_pkg::pixel_t    base_pixel,
  input  rpbm_pkg::pixel_t    first_source_pixel,
  input  rpbm_pkg::pixel_t    second_source_pixel,
  input  rpbm_pkg::pixel_t    third_source_pixel,
  output logic                merged_valid,
  input  logic                merged_ready,
  output rpbm_pkg::pixel_t    merged_pixel,
  input  logic                cfg_write,
  input  rpbm_pkg::cfg_index_t cfg_index,
  input  rpbm_pkg::cfg_t      cfg_data
);
  import rpbm_pkg::*;

  localparam int F = MAX_SOURCES - 1;
  localparam int NS = 2 * F + 1;
  localparam int PW = CHAN_W * MAX_SOURCES;
  localparam int NW = (F > 1) ? $clog2(F + 1) : 1;

  typedef struct packed {
    cfg_t                      mode;
    logic [NW-1:0]             n;
    chan_t                     alpha;
    logic [2:0][PW-1:0]        acc;
    logic [F-1:0][PIXEL_W-1:0] src;
  } stage_t;

  cfg_t blend_mode;
  cfg_t source_count;

  stage_t stg [NS];
  stage_t stg_next [NS];
  logic [NS-1:0] valid;
  logic [NS-1:0] ready;

  logic [2:0][PIXEL_W-1:0] src_in;
  cfg_t cnt;

  assign src_in = {third_source_pixel, second_source_pixel, first_source_pixel};
  assign cnt = (source_count > CFG_W'(MAX_SOURCES)) ? CFG_W'(MAX_SOURCES) : source_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= RESET_BLEND_MODE;
      source_count <= RESET_SOURCE_COUNT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BLEND_MODE: blend_mode <= cfg_data;
        REG_SOURCE_COUNT: source_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ready[NS-1] = !valid[NS-1] || merged_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      ready[s] = !valid[s] || ready[s+1];
    end
  end

  always_comb begin
    logic [CHAN_W:0] sum;
    chan_t v;
    chan_t c;
    int j;
    sum = '0;
    v = '0;
    c = '0;
    j = 0;
    stg_next[0].mode = blend_mode;
    stg_next[0].n = (cnt == '0) ? '0 : NW'(cnt - 3'd1);
    stg_next[0].alpha = OPAQUE;
    for (int ch = 0; ch < 3; ch++) begin
      stg_next[0].acc[ch] = PW'(base_pixel[CHAN_W*ch +: CHAN_W]);
    end
    for (int k = 0; k < F; k++) begin
      stg_next[0].src[k] = src_in[k];
    end
    for (int s = 1; s < NS; s++) begin
      stg_next[s] = stg[s-1];
      if (s <= F) begin
        j = s - 1;
        if (j < int'(stg[s-1].n)) begin
          if (stg[s-1].mode == MODE_ALPHA) begin
            stg_next[s].alpha = stg[s-1].src[j][23:16];
          end
          for (int ch = 0; ch < 3; ch++) begin
            c = stg[s-1].src[j][CHAN_W*ch +: CHAN_W];
            v = stg[s-1].acc[ch][CHAN_W-1:0];
            sum = {1'b0, v} + {1'b0, c};
            unique case (stg[s-1].mode)
              MODE_ADD_CLAMP: stg_next[s].acc[ch] = PW'(sum[CHAN_W] ? OPAQUE : sum[CHAN_W-1:0]);
              MODE_ADD_WRAP:  stg_next[s].acc[ch] = PW'(sum[CHAN_W-1:0]);
              MODE_SUB_CLAMP: stg_next[s].acc[ch] = PW'((v > c) ? chan_t'(v - c) : '0);
              MODE_SUB_WRAP:  stg_next[s].acc[ch] = PW'(chan_t'(v - c));
              MODE_MULTIPLY:  stg_next[s].acc[ch] = stg[s-1].acc[ch] * PW'(c);
              default: ;
            endcase
          end
        end
      end else begin
        j = s - F - 1;
        if (stg[s-1].mode == MODE_MULTIPLY && j < int'(stg[s-1].n)) begin
          for (int ch = 0; ch < 3; ch++) begin
            stg_next[s].acc[ch] = PW'(div255(32'(stg[s-1].acc[ch])));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= pixel_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (ready[s]) begin
          valid[s] <= valid[s-1];
        end
      end
    end
    for (int s = 0; s < NS; s++) begin
      if (ready[s]) begin
        stg[s] <= stg_next[s];
      end
    end
  end

  assign pixel_ready = ready[0];
  assign merged_valid = valid[NS-1];
  assign merged_pixel = {stg[NS-1].alpha,
                         stg[NS-1].acc[2][CHAN_W-1:0],
                         stg[NS-1].acc[1][CHAN_W-1:0],
                         stg[NS-1].acc[0][CHAN_W-1:0]};

endmodule

/* hdl/rpbm_checker.sv */
module rpbm_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 pixel_valid,
  input logic                 pixel_ready,
  input logic                 merged_valid,
  input logic                 merged_ready,
  input rpbm_pkg::pixel_t     merged_pixel,
  input logic                 cfg_write,
  input rpbm_pkg::cfg_index_t cfg_index,
  input rpbm_pkg::cfg_t       cfg_data
);
  import rpbm_pkg::*;

  cfg_t shadow_mode;
  cfg_t shadow_count;
  logic [4:0] in_flight;

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_mode <= RESET_BLEND_MODE;
      shadow_count <= RESET_SOURCE_COUNT;
      in_flight <= '0;
    end else begin
      if (cfg_write && cfg_index == REG_BLEND_MODE) begin
        shadow_mode <= cfg_data;
      end
      if (cfg_write && cfg_index == REG_SOURCE_COUNT) begin
        shadow_count <= cfg_data;
      end
      in_flight <= in_flight + 5'(pixel_valid && pixel_ready)
                   - 5'(merged_valid && merged_ready);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !merged_valid)
    else $error("Output valid after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    merged_valid && !merged_ready |=> merged_valid && $stable(merged_pixel))
    else $error("Stalled output changed.");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    merged_ready |-> pixel_ready)
    else $error("Input stalled while the output side is ready.");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    merged_valid |-> in_flight != '0)
    else $error("Output transfer without a matching input transfer.");

  a_opaque: assert property (@(posedge clk) disable iff (rst)
    merged_valid && (shadow_mode != MODE_ALPHA || shadow_count <= 3'd1)
      |-> merged_pixel[31:24] == OPAQUE)
    else $error("Alpha not opaque outside alpha mode.");

endmodule

bind rgb_pixel_blend_merge rpbm_checker u_rpbm_checker (.*);

/* dv/merged_pixel_checker.sv */
`timescale 1ns / 1ps
module merged_pixel_checker #(
  parameter int MAX_SOURCES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pixel_valid,
  input  logic                 pixel_ready,
  input  rpbm_pkg::pixel_t     base_pixel,
  input  rpbm_pkg::pixel_t     first_source_pixel,
  input  rpbm_pkg::pixel_t     second_source_pixel,
  input  rpbm_pkg::pixel_t     third_source_pixel,
  input  logic                 merged_valid,
  input  logic                 merged_ready,
  input  rpbm_pkg::pixel_t     merged_pixel,
  input  logic                 cfg_write,
  input  rpbm_pkg::cfg_index_t cfg_index,
  input  rpbm_pkg::cfg_t       cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   merged_checked
);
  import rpbm_pkg::*;

  cfg_t blend_mode;
  cfg_t source_count;
  pixel_t expected_merged [$];

  function automatic pixel_t blend_pixel(cfg_t mode, cfg_t count, pixel_t base,
                                         pixel_t src0, pixel_t src1, pixel_t src2);
    pixel_t src [3];
    int unsigned active;
    int unsigned sh;
    int unsigned acc;
    int unsigned c;
    longint unsigned num;
    longint unsigned den;
    pixel_t result;
    src[0] = src0;
    src[1] = src1;
    src[2] = src2;
    active = (count > MAX_SOURCES) ? MAX_SOURCES : count;
    active = (active > 0) ? active - 1 : 0;
    if (active > 3) active = 3;
    result = {OPAQUE, 24'd0};
    for (int ch = 0; ch < 3; ch++) begin
      sh = ch * CHAN_W;
      acc = (base >> sh) & 8'hFF;
      num = acc;
      den = 1;
      for (int i = 0; i < active; i++) begin
        c = (src[i] >> sh) & 8'hFF;
        case (mode)
          MODE_ADD_CLAMP: acc = (acc + c > OPAQUE) ? OPAQUE : acc + c;
          MODE_ADD_WRAP:  acc = (acc + c) & 8'hFF;
          MODE_SUB_CLAMP: acc = (acc > c) ? acc - c : 0;
          MODE_SUB_WRAP:  acc = (acc - c) & 8'hFF;
          MODE_MULTIPLY: begin
            num = num * c;
            den = den * OPAQUE;
          end
          default: ;
        endcase
      end
      if (mode == MODE_MULTIPLY) acc = int'(num / den);
      result[sh +: CHAN_W] = acc[CHAN_W-1:0];
    end
    if (mode == MODE_ALPHA && active > 0) begin
      result[3*CHAN_W +: CHAN_W] = src[active-1][2*CHAN_W +: CHAN_W];
    end
    return result;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      blend_mode <= RESET_BLEND_MODE;
      source_count <= RESET_SOURCE_COUNT;
      expected_merged.delete();
      mismatches = 0;
      outstanding = 0;
      merged_checked = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BLEND_MODE:   blend_mode <= cfg_data;
          REG_SOURCE_COUNT: source_count <= cfg_data;
          default: ;
        endcase
      end
      if (pixel_valid && pixel_ready) begin
        expected_merged.push_back(blend_pixel(blend_mode, source_count, base_pixel,
                                              first_source_pixel, second_source_pixel,
                                              third_source_pixel));
      end
      if (merged_valid && merged_ready) begin
        if (expected_merged.size() == 0) begin
          $error("merged_pixel transfer with nothing expected: actual %h", merged_pixel);
          mismatches++;
        end else begin
          if (merged_pixel !== expected_merged[0]) begin
            $error("merged_pixel mismatch: expected %h, actual %h",
                   expected_merged[0], merged_pixel);
            mismatches++;
          end
          void'(expected_merged.pop_front());
          merged_checked++;
        end
      end
      outstanding = expected_merged.size();
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import rpbm_pkg::*;

  localparam int MAX_SOURCES = 4;
  localparam int LATENCY = 2 * MAX_SOURCES - 1;
  localparam int RANDOM_ITEMS = 400;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam cfg_t MODE_UNDEF_LO = 3'd6;
  localparam cfg_t MODE_UNDEF_HI = 3'd7;
  localparam pixel_t PIX_ZERO = 32'h0000_0000;
  localparam pixel_t PIX_FULL = 32'hFFFF_FFFF;
  localparam pixel_t PIX_HALF = 32'h8080_8080;
  localparam pixel_t PIX_ONE = 32'h0101_0101;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_ready;
  pixel_t base_pixel = '0;
  pixel_t first_source_pixel = '0;
  pixel_t second_source_pixel = '0;
  pixel_t third_source_pixel = '0;
  logic merged_valid;
  logic merged_ready = 1'b0;
  pixel_t merged_pixel;
  logic cfg_write = 1'b0;
  cfg_index_t cfg_index = REG_BLEND_MODE;
  cfg_t cfg_data = '0;

  int mismatches;
  int outstanding;
  int merged_checked;

  bit steady = 1'b0;
  int pixels_sent = 0;
  int random_sent = 0;
  int settings_applied = 0;
  bit [7:0] modes_seen = 8'b0;
  bit [7:0] counts_seen = 8'b0;
  int ready_hold = 0;
  int quiet_cycles = 0;
  int phase_len;
  cfg_t next_mode;
  cfg_t next_count;
  int pick;

  always #5 clk = ~clk;

  rgb_pixel_blend_merge #(.MAX_SOURCES(MAX_SOURCES)) dut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .base_pixel(base_pixel), .first_source_pixel(first_source_pixel),
    .second_source_pixel(second_source_pixel), .third_source_pixel(third_source_pixel),
    .merged_valid(merged_valid), .merged_ready(merged_ready), .merged_pixel(merged_pixel),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  merged_pixel_checker #(.MAX_SOURCES(MAX_SOURCES)) pixel_checker (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .base_pixel(base_pixel), .first_source_pixel(first_source_pixel),
    .second_source_pixel(second_source_pixel), .third_source_pixel(third_source_pixel),
    .merged_valid(merged_valid), .merged_ready(merged_ready), .merged_pixel(merged_pixel),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding), .merged_checked(merged_checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int r;
    r = $urandom_range(0, 9);
    p = $urandom;
    if (r == 0) p = PIX_ZERO;
    else if (r == 1) p = PIX_FULL;
    else if (r == 2) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 5))
          0: p[i*CHAN_W +: CHAN_W] = 8'h00;
          1: p[i*CHAN_W +: CHAN_W] = 8'hFF;
          2: p[i*CHAN_W +: CHAN_W] = 8'h01;
          3: p[i*CHAN_W +: CHAN_W] = 8'hFE;
          4: p[i*CHAN_W +: CHAN_W] = 8'h80;
          default: p[i*CHAN_W +: CHAN_W] = 8'h7F;
        endcase
      end
    end
    return p;
  endfunction

  task automatic send_pixel(input pixel_t b, input pixel_t s1, input pixel_t s2,
                            input pixel_t s3);
    int gap;
    @(negedge clk);
    pixel_valid <= 1'b1;
    base_pixel <= b;
    first_source_pixel <= s1;
    second_source_pixel <= s2;
    third_source_pixel <= s3;
    do @(posedge clk); while (!pixel_ready);
    pixels_sent++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      pixel_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_random();
    send_pixel(rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel());
  endtask

  // The pipeline must be empty before a register changes under it.
  task automatic apply_config(input cfg_t mode, input cfg_t count);
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_BLEND_MODE;
    cfg_data <= mode;
    @(negedge clk);
    cfg_index <= REG_SOURCE_COUNT;
    cfg_data <= count;
    @(negedge clk);
    cfg_write <= 1'b0;
    modes_seen[mode] = 1'b1;
    counts_seen[count] = 1'b1;
    settings_applied++;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      merged_ready <= 1'b0;
      ready_hold = 0;
    end else if (steady) begin
      merged_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if (merged_ready) begin
      ready_hold = pick_gap();
      if (ready_hold > 0) begin
        merged_ready <= 1'b0;
        ready_hold--;
      end
    end else begin
      merged_ready <= 1'b1;
      ready_hold = $urandom_range(0, 7);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((pixel_valid && pixel_ready) || (merged_valid && merged_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("rgb_pixel_blend_merge test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    modes_seen[RESET_BLEND_MODE] = 1'b1;
    counts_seen[RESET_SOURCE_COUNT] = 1'b1;

    send_random();
    apply_config(MODE_ADD_CLAMP, 3'd4);
    send_pixel(PIX_FULL, PIX_FULL, PIX_FULL, PIX_FULL);
    send_pixel(PIX_HALF, PIX_HALF, PIX_ONE, PIX_ZERO);
    apply_config(MODE_ADD_WRAP, 3'd4);
    send_pixel(PIX_HALF, PIX_HALF, PIX_ONE, 32'h7F7F_7F7F);
    apply_config(MODE_SUB_CLAMP, 3'd4);
    send_pixel(PIX_ZERO, PIX_FULL, PIX_FULL, PIX_FULL);
    send_pixel(PIX_FULL, PIX_ONE, PIX_ONE, PIX_ONE);
    apply_config(MODE_SUB_WRAP, 3'd4);
    send_pixel(PIX_ZERO, PIX_ONE, PIX_HALF, PIX_ZERO);
    apply_config(MODE_MULTIPLY, 3'd4);
    send_pixel(PIX_FULL, PIX_FULL, PIX_FULL, PIX_FULL);
    send_pixel(PIX_ZERO, rand_pixel(), rand_pixel(), rand_pixel());
    send_pixel(PIX_HALF, PIX_HALF, PIX_HALF, PIX_HALF);
    apply_config(MODE_MULTIPLY, 3'd2);
    send_random();
    apply_config(MODE_ALPHA, 3'd3);
    send_random();
    apply_config(MODE_ALPHA, 3'd1);
    send_random();
    apply_config(MODE_UNDEF_LO, 3'd4);
    send_random();
    apply_config(MODE_UNDEF_HI, 3'd2);
    send_random();
    apply_config(MODE_ADD_CLAMP, 3'd0);
    send_random();
    apply_config(MODE_ADD_WRAP, 3'd7);
    send_random();
    apply_config(MODE_MULTIPLY, 3'd5);
    send_random();

    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) < 17) next_mode = cfg_t'($urandom_range(0, 5));
      else next_mode = cfg_t'($urandom_range(6, 7));
      if ($urandom_range(0, 4) == 0) begin
        pick = $urandom_range(0, 3);
        next_count = (pick == 0) ? cfg_t'(0) : cfg_t'(pick + 4);
      end else begin
        next_count = cfg_t'($urandom_range(1, 4));
      end
      apply_config(next_mode, next_count);
      steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(10, 40);
      repeat (phase_len) begin
        send_random();
        random_sent++;
      end
      steady = 1'b0;
    end

    @(negedge clk);
    pixel_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (2 * LATENCY + 5) @(posedge clk);

    $display("Covered %0d pixels over %0d register settings (mode codes %b, counts %b).",
             pixels_sent, settings_applied, modes_seen, counts_seen);
    $display("Compared %0d merged pixels with %0d mismatches.", merged_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("rgb_pixel_blend_merge test passed");
    end else begin
      $display("rgb_pixel_blend_merge test failed");
    end
    $finish;
  end

endmodule
